@@ hdl/tarm_pkg.sv @@
// Shared types, constants and the arctangent table for the arc rotation mover.
// No dependencies; compiled first.
package tarm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CNT_W        = $clog2(TABLE_LEN + 1);

  localparam int XW   = 58;  // CORDIC x/y: Q15.8 scaled by 2^30, plus growth
  localparam int ZW   = 34;  // angle accumulator, 2^32 units per turn
  localparam int QW   = 16;  // rate quotient bits
  localparam logic [30:0] GAIN_Q30 = 31'd652032874;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ANG, S_MULX, S_MULY, S_CST, S_ROT, S_DONE
  } tarm_state_t;

  typedef enum logic [1:0] {
    REG_CENTER_X, REG_CENTER_Y, REG_SWEEP_TIME, REG_SWEEP_ANGLE
  } tarm_reg_t;

  typedef struct packed {
    logic start;
  } tarm_go_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tarm_stat_t;

  function automatic logic [29:0] arc_lut(input logic [CNT_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/tarm_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing.
interface tarm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic        [15:0] tick_dt;
  modport source (output valid, mode, pos_x, pos_y, tick_dt, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, tick_dt, output ready);
endinterface

interface tarm_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic               moved;
  logic               active;
  modport source (output valid, out_x, out_y, moved, active, input ready);
  modport sink   (input valid, out_x, out_y, moved, active, output ready);
endinterface

@@ hdl/tarm_div.sv @@
// Serial restoring divider: 16 quotient bits of (num << 16) / den, one per cycle.
// Depends on tarm_pkg. Quotient is only meaningful when num < den.
module tarm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tarm_pkg::tarm_go_t   go,
  input  logic [31:0]          num,
  input  logic [31:0]          den,
  output tarm_pkg::tarm_stat_t stat,
  output logic [15:0]          quo
);
  import tarm_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic ge;

  assign trial = {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, den};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go.start) begin
      rem_nxt  = num;
      q_nxt    = '0;
      cnt_nxt  = 5'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(trial - {1'b0, den}) : trial[31:0];
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;

endmodule

@@ hdl/tarm_cordic.sv @@
// Iterative CORDIC rotator: one shift/add/subtract micro-rotation per cycle.
// Depends on tarm_pkg for widths, step count and the arctangent table.
module tarm_cordic (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tarm_pkg::tarm_go_t     go,
  input  logic signed [57:0]     x0,
  input  logic signed [57:0]     y0,
  input  logic signed [33:0]     z0,
  output tarm_pkg::tarm_stat_t   stat,
  output logic signed [57:0]     xo,
  output logic signed [57:0]     yo
);
  import tarm_pkg::*;

  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_r, z_nxt, at;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = $signed({4'b0, arc_lut(i_r)});

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go.start) begin
      x_nxt    = x0;
      y_nxt    = y0;
      z_nxt    = z0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == CNT_W'(NSTEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign xo        = x_r;
  assign yo        = y_r;

endmodule

@@ hdl/timed_arc_rotation_mover.sv @@
// Top level of the arc rotation mover: config registers, sequencer, output register.
// Depends on tarm_pkg, tarm_if, tarm_div and tarm_cordic.
//
// Usage:
//   in_ch  carries items (mode 0 = start from pos_x/pos_y, mode 1 = tick of
//   tick_dt). out_ch returns exactly one result per item. The cfg port
//   (cfg_we, cfg_index, cfg_data) writes center_x, center_y, the sweep
//   duration and sweep_angle; write only while no item is in flight.
//   in_ch.ready is high only while the sequencer is idle; one item at a time.
//   Path from input transfer to the result:
//     start item or finished tick: straight to the final state;
//     moving tick: 16 divider steps for the rate, one
//     multiply for the angle, two gain multiplies on the shared multiplier,
//     then CORDIC_STEPS micro-rotations on the shift/add unit.
//   A new item is accepted only after the result of the previous one has
//   been loaded into the output register.
//   The result sits in an output register; while an earlier result there
//   is untaken and out_ch.ready is low, the sequencer holds in its final
//   state and accepts nothing. Reset (rst_n low, synchronous) restores
//   the register defaults (sweep duration 1.0 s), clears offset and elapsed
//   time, and drops any pending result.
module timed_arc_rotation_mover (
  input  logic        clk,
  input  logic        rst_n,
  tarm_in_if.sink     in_ch,
  tarm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tarm_pkg::*;

  tarm_state_t state_r, state_nxt;

  logic signed [23:0] cx_r, cy_r;
  logic [31:0] lim_r;
  logic signed [21:0] sw_r;
  logic signed [24:0] offx_r, offy_r;
  logic [31:0] ela_r;
  logic mv_r, act_r;
  logic [15:0] ang_r;
  logic signed [XW-1:0] x_r, y_r;

  logic in_fire, finished, out_free;
  logic [32:0] ela_sum;
  logic [31:0] ela_sat;
  tarm_go_t div_go, cor_go;
  tarm_stat_t div_st, cor_st;
  logic [15:0] quo;

  logic [21:0] mag;
  logic [16:0] rate;
  logic [38:0] prod;
  logic [15:0] p16;

  logic signed [24:0] mul_a;
  logic signed [55:0] mul_p;

  logic flip;
  logic [15:0] angq;
  logic signed [XW-1:0] cx0, cy0;
  logic signed [ZW-1:0] cz0;
  logic signed [XW-1:0] cor_x, cor_y, rx_s, ry_s;
  logic signed [28:0] sum_x, sum_y;

  logic out_valid_r;
  logic signed [23:0] ox_r, oy_r;
  logic omv_r, oact_r;
  logic load_out;

  function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
    if (v > 29'sd8388607)       return 24'sh7FFFFF;
    else if (v < -29'sd8388608) return 24'sh800000;
    else                        return v[23:0];
  endfunction

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      lim_r <= 32'd65536;
      sw_r  <= '0;
    end else if (cfg_we) begin
      case (tarm_reg_t'(cfg_index))
        REG_CENTER_X:    cx_r  <= cfg_data[23:0];
        REG_CENTER_Y:    cy_r  <= cfg_data[23:0];
        REG_SWEEP_TIME:  lim_r <= cfg_data;
        REG_SWEEP_ANGLE: sw_r  <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign finished = lim_r <= ela_r;
  assign ela_sum  = {1'b0, ela_r} + {17'b0, in_ch.tick_dt};
  assign ela_sat  = ela_sum[32] ? 32'hFFFFFFFF : ela_sum[31:0];
  assign out_free = !out_valid_r || out_ch.ready;

  // rate and angle
  assign mag  = sw_r[21] ? 22'(-sw_r) : sw_r;
  assign rate = (ela_r >= lim_r) ? 17'h10000 : {1'b0, quo};
  assign prod = {17'b0, mag} * {22'b0, rate};
  assign p16  = prod[31:16];

  // shared gain multiplier
  assign mul_a = (state_r == S_MULX) ? offx_r : offy_r;
  assign mul_p = mul_a * $signed({1'b0, GAIN_Q30});

  // half-turn fold for 2nd/3rd quadrant
  always_comb begin
    flip = 1'b0;
    case (ang_r) inside
      [16'd16384:16'd49151]: flip = 1'b1;
      default:               flip = 1'b0;
    endcase
  end
  assign angq = flip ? 16'(ang_r + 16'd32768) : ang_r;
  assign cx0  = flip ? -x_r : x_r;
  assign cy0  = flip ? -y_r : y_r;
  assign cz0  = ZW'($signed({angq, 16'b0}));

  tarm_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(ela_sat), .den(lim_r),
    .stat(div_st), .quo(quo)
  );

  tarm_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cor_go), .x0(cx0), .y0(cy0), .z0(cz0),
    .stat(cor_st), .xo(cor_x), .yo(cor_y)
  );

  // round half up back to Q15.8, add center, saturate
  assign rx_s  = cor_x + (XW'(1) <<< 29);
  assign ry_s  = cor_y + (XW'(1) <<< 29);
  assign sum_x = 29'(cx_r) + 29'($signed(rx_s[57:30]));
  assign sum_y = 29'(cy_r) + 29'($signed(ry_s[57:30]));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode && !finished) state_nxt = S_DIV;
          else                         state_nxt = S_DONE;
        end
      end
      S_DIV:  if (div_st.done) state_nxt = S_ANG;
      S_ANG:  state_nxt = S_MULX;
      S_MULX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_CST;
      S_CST:  state_nxt = S_ROT;
      S_ROT:  if (cor_st.done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    div_go.start = 1'b0;
    cor_go.start = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready  = 1'b1;
        div_go.start = in_ch.valid && in_ch.mode && !finished;
      end
      S_CST:  cor_go.start = 1'b1;
      S_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      offx_r  <= '0;
      offy_r  <= '0;
      ela_r   <= '0;
      mv_r    <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        if (!in_ch.mode) begin
          offx_r <= 25'(in_ch.pos_x) - 25'(cx_r);
          offy_r <= 25'(in_ch.pos_y) - 25'(cy_r);
          ela_r  <= '0;
          mv_r   <= 1'b0;
          act_r  <= 1'b1;
        end else if (finished) begin
          mv_r  <= 1'b0;
          act_r <= 1'b0;
        end else begin
          ela_r <= ela_sat;
          mv_r  <= 1'b1;
          act_r <= ela_sat < lim_r;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_ANG)
      ang_r <= sw_r[21] ? 16'(16'd0 - p16) : p16;
    if (state_r == S_MULX)
      x_r <= XW'(mul_p);
    if (state_r == S_MULY)
      y_r <= XW'(mul_p);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      ox_r   <= mv_r ? sat24(sum_x) : '0;
      oy_r   <= mv_r ? sat24(sum_y) : '0;
      omv_r  <= mv_r;
      oact_r <= act_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_x  = ox_r;
  assign out_ch.out_y  = oy_r;
  assign out_ch.moved  = omv_r;
  assign out_ch.active = oact_r;

`ifndef SYNTHESIS
  a_ela_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(ela_r))
    else $error("elapsed changed while an item was in flight");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_cor_done: assert property (@(posedge clk) disable iff (!rst_n)
    cor_st.done |-> (state_r == S_ROT))
    else $error("rotator finished outside the rotate state");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.moved) |-> (out_ch.out_x == 24'sd0 && out_ch.out_y == 24'sd0))
    else $error("non-moving result carries a position");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (state_r == S_IDLE && out_ch.valid))
    else $error("result load did not complete the item");
`endif

endmodule
